FILE: sv/fxa_pkg.sv
// fixed-point alu package: mode codes, payload and work types, saturation helper
// no dependencies
package fxa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int NUM_W         = 48;

	localparam logic [3:0] MODE_ADD = 4'd0;
	localparam logic [3:0] MODE_SUB = 4'd1;
	localparam logic [3:0] MODE_MUL = 4'd2;
	localparam logic [3:0] MODE_DIV = 4'd3;
	localparam logic [3:0] MODE_MIN = 4'd4;
	localparam logic [3:0] MODE_MAX = 4'd5;
	localparam logic [3:0] MODE_INC = 4'd6;
	localparam logic [3:0] MODE_DEC = 4'd7;
	localparam logic [3:0] MODE_I2F = 4'd8;
	localparam logic [3:0] MODE_F2I = 4'd9;

	localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
	localparam logic signed [31:0] MIN32 = 32'sh80000000;

	typedef struct packed {
		logic [3:0]         mode;
		logic signed [31:0] left_raw;
		logic signed [31:0] right_raw;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               is_less;
		logic               is_equal;
		logic               is_greater;
		logic               overflow_flag;
		logic               divide_by_zero;
	} out_t;

	typedef struct packed {
		logic [3:0]         mode;
		logic               neg;
		logic               lt;
		logic               eq;
		logic               gt;
		logic signed [31:0] simple_res;
		logic               simple_ovf;
		logic               dz;
		logic [31:0]        den;
		logic [NUM_W-1:0]   num;
		logic [31:0]        rem;
		logic [NUM_W-1:0]   quo;
		logic [63:0]        prod;
	} work_t;

	// {overflow, value} for a signed magnitude clamped to 32 bits
	function automatic logic [32:0] sat_mag(input logic [63:0] mag, input logic neg);
		logic [32:0] r;
		if (neg) begin
			if (mag > 64'h8000_0000) r = {1'b1, MIN32};
			else r = {1'b0, 32'(-mag[31:0])};
		end else begin
			if (mag > 64'h7fff_ffff) r = {1'b1, MAX32};
			else r = {1'b0, mag[31:0]};
		end
		return r;
	endfunction

endpackage

FILE: sv/fxa_stream_if.sv
// valid/ready channel carrying one payload per transfer
// depends on nothing; payload type is a parameter
interface fxa_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: sv/fxa_prep.sv
// front stage: magnitudes, compare flags, multiply, simple operations
// depends on fxa_pkg
module fxa_prep #(
	parameter int FRACTION_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fxa_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output fxa_pkg::work_t out_data
);
	import fxa_pkg::*;

	localparam logic signed [32:0] ONE  = 33'sd1 <<< FRACTION_BITS;
	localparam logic [32:0]        HALF = 33'd1 << (FRACTION_BITS - 1);

	logic               v_s1;
	work_t              w_s1;
	work_t              w;
	logic signed [31:0] l, r;
	logic [31:0]        mag_l, mag_r;
	logic signed [32:0] sum;
	logic signed [47:0] ext;
	logic [32:0]        f2i;
	logic               do_sat;

	assign l     = in_data.left_raw;
	assign r     = in_data.right_raw;
	assign mag_l = l[31] ? 32'(-l) : 32'(l);
	assign mag_r = r[31] ? 32'(-r) : 32'(r);

	always_comb begin
		w            = '0;
		w.mode       = in_data.mode;
		w.neg        = l[31] ^ r[31];
		w.lt         = l < r;
		w.eq         = l == r;
		w.gt         = l > r;
		w.den        = mag_r;
		w.num        = {mag_l, 16'b0};
		w.prod       = 64'(mag_l) * 64'(mag_r);
		w.dz         = (in_data.mode == MODE_DIV) && (r == 32'sd0);
		sum          = '0;
		do_sat       = 1'b0;
		ext          = {{16{l[31]}}, l} <<< FRACTION_BITS;
		f2i          = ({1'b0, mag_l} + HALF) >> FRACTION_BITS;
		case (in_data.mode)
			MODE_ADD: begin sum = {l[31], l} + {r[31], r}; do_sat = 1'b1; end
			MODE_SUB: begin sum = {l[31], l} - {r[31], r}; do_sat = 1'b1; end
			MODE_INC: begin sum = {l[31], l} + ONE; do_sat = 1'b1; end
			MODE_DEC: begin sum = {l[31], l} - ONE; do_sat = 1'b1; end
			MODE_MIN: w.simple_res = (l < r) ? l : r;
			MODE_MAX: w.simple_res = (l > r) ? l : r;
			MODE_I2F: begin
				if (ext[47:31] == {17{1'b0}} || ext[47:31] == {17{1'b1}}) begin
					w.simple_res = ext[31:0];
				end else begin
					w.simple_ovf = 1'b1;
					w.simple_res = ext[47] ? MIN32 : MAX32;
				end
			end
			MODE_F2I: w.simple_res = l[31] ? 32'(-f2i[31:0]) : f2i[31:0];
			default: w.simple_res = '0;
		endcase
		if (do_sat) begin
			if (sum[32] != sum[31]) begin
				w.simple_ovf = 1'b1;
				w.simple_res = sum[32] ? MIN32 : MAX32;
			end else begin
				w.simple_res = sum[31:0];
			end
		end
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) w_s1 <= w;
	end

	assign out_valid = v_s1;
	assign out_data  = w_s1;
endmodule

FILE: sv/fxa_div_cell.sv
// one restoring division step: one quotient bit per cell
// depends on fxa_pkg
module fxa_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fxa_pkg::work_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fxa_pkg::work_t out_data
);
	import fxa_pkg::*;

	logic        v_q;
	work_t       w_q;
	work_t       w;
	logic [32:0] trial;
	logic        ge;

	always_comb begin
		trial = {in_data.rem, in_data.num[NUM_W-1]};
		ge    = trial >= {1'b0, in_data.den};
		w     = in_data;
		w.rem = ge ? 32'(trial - {1'b0, in_data.den}) : trial[31:0];
		w.quo = {in_data.quo[NUM_W-2:0], ge};
		w.num = {in_data.num[NUM_W-2:0], 1'b0};
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) w_q <= w;
	end

	assign out_valid = v_q;
	assign out_data  = w_q;
endmodule

FILE: sv/fxa_finish.sv
// output stage: rounding and saturation of multiply and divide, result register
// depends on fxa_pkg
module fxa_finish #(
	parameter int FRACTION_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fxa_pkg::work_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output fxa_pkg::out_t  out_data
);
	import fxa_pkg::*;

	localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

	logic        v_q;
	out_t        o_q;
	out_t        o;
	logic [32:0] sat;
	logic [63:0] qr;
	logic        up;

	always_comb begin
		o                = '0;
		o.is_less        = in_data.lt;
		o.is_equal       = in_data.eq;
		o.is_greater     = in_data.gt;
		o.divide_by_zero = in_data.dz;
		up               = {in_data.rem, 1'b0} >= {1'b0, in_data.den};
		qr               = '0;
		sat              = '0;
		case (in_data.mode)
			MODE_MUL: begin
				qr  = (in_data.prod + HALF) >> FRACTION_BITS;
				sat = sat_mag(qr, in_data.neg);
				o.result_value  = sat[31:0];
				o.overflow_flag = sat[32];
			end
			MODE_DIV: begin
				if (!in_data.dz) begin
					qr  = 64'(in_data.quo) + 64'(up);
					sat = sat_mag(qr, in_data.neg);
					o.result_value  = sat[31:0];
					o.overflow_flag = sat[32];
				end
			end
			default: begin
				o.result_value  = in_data.simple_res;
				o.overflow_flag = in_data.simple_ovf;
			end
		endcase
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) o_q <= o;
	end

	assign out_valid = v_q;
	assign out_data  = o_q;
endmodule

FILE: sv/q24_8_fixed_point_alu_top.sv
// signed fixed-point alu: front stage, a row of division cells, output stage
// one fxa_prep front stage, 32 + FRACTION_BITS fxa_div_cell cells, one fxa_finish stage
// one item per cycle while rsp is ready; each cell holds one item, stalls only when full
// the divide row is one quotient bit per cell; the multiply sits in the front stage
// reset clears the valid bits only; also depends on fxa_pkg and fxa_stream_if
module q24_8_fixed_point_alu_top #(
	parameter int FRACTION_BITS = fxa_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fxa_stream_if.sink   req,
	fxa_stream_if.source rsp
);
	import fxa_pkg::*;

	localparam int N_CELLS = 32 + FRACTION_BITS;

	work_t w   [N_CELLS+1];
	logic  v   [N_CELLS+1];
	logic  rdy [N_CELLS+1];

	fxa_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.out_valid(v[0]), .out_ready(rdy[0]), .out_data(w[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		fxa_div_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(v[i]), .in_ready(rdy[i]), .in_data(w[i]),
			.out_valid(v[i+1]), .out_ready(rdy[i+1]), .out_data(w[i+1])
		);
	end

	fxa_finish #(.FRACTION_BITS(FRACTION_BITS)) u_finish (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v[N_CELLS]), .in_ready(rdy[N_CELLS]), .in_data(w[N_CELLS]),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
	);
endmodule
